### rtl/core/seven_segment_scan_driver_assert.svh
// ----------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// Same-cycle implication.
`define SSSD_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSSD_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, codes and the segment table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

  localparam int KIND_W      = 2;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SEG_W       = 7;
  localparam int DIG_LINES_W = 8;
  localparam int CODE_W      = 4;
  localparam int TICK_W      = 16;
  localparam int DCOUNT_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_OFF  = 2'd3
  } kind_t;

  // Classified request handed from front to back.
  typedef enum logic [2:0] {
    OP_SYM,
    OP_POINT,
    OP_BAD,
    OP_END,
    OP_TICK,
    OP_OFF
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIGN_POS    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_TICKS  = 2'd2;

  localparam logic [DCOUNT_W-1:0] DIGIT_COUNT_RST = 4'd4;
  localparam logic [TICK_W-1:0]   SCAN_TICKS_RST  = 16'd5500;

  // Symbol codes: 0 blank, 1..9 digits, 10 digit zero, 11 minus, 15 none.
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd0;
  localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd10;
  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd11;
  localparam logic [CODE_W-1:0] CODE_NONE  = 4'd15;

  localparam logic [IN_DATA_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [IN_DATA_W-1:0] CHAR_ONE   = 8'h31;
  localparam logic [IN_DATA_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [IN_DATA_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [IN_DATA_W-1:0] CHAR_POINT = 8'h2E;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } item_t;

  typedef struct packed {
    logic              pt;
    logic [CODE_W-1:0] code;
  } sym_t;

  typedef struct packed {
    logic [DCOUNT_W-1:0] digit_count;
    logic                sign_positive;
    logic [TICK_W-1:0]   scan_ticks;
  } cfg_t;

  // Segment pattern, bit0 = a .. bit6 = g, active high.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] p;
    case (code)
      4'd1:       p = 7'h06;
      4'd2:       p = 7'h5B;
      4'd3:       p = 7'h4F;
      4'd4:       p = 7'h66;
      4'd5:       p = 7'h6D;
      4'd6:       p = 7'h7D;
      4'd7:       p = 7'h07;
      4'd8:       p = 7'h7F;
      4'd9:       p = 7'h67;
      CODE_ZERO:  p = 7'h3F;
      CODE_MINUS: p = 7'h40;
      default:    p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/sssd_front.sv
// ----------------------------------------------------------------------------
// sssd_front
// Accepts input requests and classifies characters into symbol operations.
// ----------------------------------------------------------------------------
module sssd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sssd_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [sssd_pkg::KIND_W-1:0]    in_tuser,
  input  logic                           q_ready,
  output logic                           q_push,
  output sssd_pkg::item_t                q_item
);
  import sssd_pkg::*;

  // Hold off requests until the first cycle after reset.
  logic live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= 1'b1;
    end
  end

  assign in_tready = live_r & q_ready;
  assign q_push    = in_tvalid & in_tready;

  always_comb begin
    q_item.op   = OP_BAD;
    q_item.code = CODE_NONE;
    case (kind_t'(in_tuser))
      KIND_CHAR: begin
        if (in_tdata == CHAR_ZERO) begin
          q_item.op   = OP_SYM;
          q_item.code = CODE_ZERO;
        end else if (in_tdata inside {[CHAR_ONE:CHAR_NINE]}) begin
          q_item.op   = OP_SYM;
          q_item.code = CODE_W'(in_tdata - CHAR_ZERO);
        end else if (in_tdata == CHAR_MINUS) begin
          q_item.op   = OP_SYM;
          q_item.code = CODE_MINUS;
        end else if (in_tdata == CHAR_POINT) begin
          q_item.op   = OP_POINT;
        end else begin
          q_item.op   = OP_BAD;
        end
      end
      KIND_END:  q_item.op = OP_END;
      KIND_TICK: q_item.op = OP_TICK;
      KIND_OFF:  q_item.op = OP_OFF;
      default:   q_item.op = OP_OFF;
    endcase
  end

endmodule

### rtl/core/sssd_queue.sv
// ----------------------------------------------------------------------------
// sssd_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module sssd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sssd_pkg::item_t push_item,
  output logic            ready,
  input  logic            pop,
  output sssd_pkg::item_t pop_item,
  output logic            valid
);
  import sssd_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  assign ready    = (count_r != 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_item = slot_r[rd_ptr_r];

endmodule

### rtl/core/sssd_back.sv
// ----------------------------------------------------------------------------
// sssd_back
// Symbol staging, display buffer, scan timing and the registered line levels.
// ----------------------------------------------------------------------------
module sssd_back #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sssd_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  sssd_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sssd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sssd_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int SW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int MW = (MAX_DIGITS > DIG_LINES_W) ? MAX_DIGITS : DIG_LINES_W;

  logic [CODE_W-1:0] pend_r, pend_nxt;
  sym_t              staged_r [MAX_DIGITS];
  sym_t              staged_nxt [MAX_DIGITS];
  sym_t              staged_push [MAX_DIGITS];
  sym_t              shown_r [MAX_DIGITS];
  sym_t              shown_nxt [MAX_DIGITS];
  logic [CW-1:0]     staged_cnt_r, staged_cnt_nxt, cnt_push;
  logic [CW-1:0]     shown_cnt_r, shown_cnt_nxt;
  logic              rej_r, rej_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              on_r, on_nxt;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              push_en;
  sym_t              push_sym;
  logic              rej_out;
  logic [4:0]        dc5;
  logic [CW-1:0]     d_eff, n_cur, n_new;
  logic [SW-1:0]     si0, si_mid;
  logic [TICK_W-1:0] limit, t1;
  logic [MW-1:0]     mask, sel, dig;
  logic              lit, pt;
  logic [SEG_W-1:0]  segs;
  sym_t              cur_sym;

  assign q_pop = q_valid & (~out_valid_r | out_tready);

  always_comb begin
    // effective digit count, clamped to 1..MAX_DIGITS
    dc5 = {1'b0, cfg.digit_count};
    if (dc5 == 5'd0) begin
      d_eff = CW'(1);
    end else if (dc5 > 5'(MAX_DIGITS)) begin
      d_eff = CW'(MAX_DIGITS);
    end else begin
      d_eff = CW'(dc5);
    end
    n_cur = (shown_cnt_r < d_eff) ? shown_cnt_r : d_eff;
    si0   = (CW'(scan_r) >= d_eff) ? '0 : scan_r;

    // symbol to push into staging for this request, if any
    push_en  = 1'b0;
    push_sym = '0;
    case (q_item.op)
      OP_SYM, OP_END: begin
        if (!rej_r && pend_r != CODE_NONE) begin
          push_en  = 1'b1;
          push_sym = '{pt: 1'b0, code: pend_r};
        end
      end
      OP_POINT: begin
        if (!rej_r) begin
          push_en  = 1'b1;
          push_sym = '{pt: 1'b1, code: (pend_r == CODE_NONE) ? CODE_BLANK : pend_r};
        end
      end
      default: ;
    endcase

    staged_push[0] = push_en ? push_sym : staged_r[0];
    for (int i = 1; i < MAX_DIGITS; i++) begin
      staged_push[i] = push_en ? staged_r[i-1] : staged_r[i];
    end
    cnt_push = (push_en && staged_cnt_r != CW'(MAX_DIGITS)) ? staged_cnt_r + CW'(1)
                                                           : staged_cnt_r;

    pend_nxt       = pend_r;
    staged_nxt     = staged_r;
    staged_cnt_nxt = staged_cnt_r;
    shown_nxt      = shown_r;
    shown_cnt_nxt  = shown_cnt_r;
    rej_nxt        = rej_r;
    tick_nxt       = tick_r;
    on_nxt         = on_r;
    si_mid         = si0;
    rej_out        = rej_r;
    limit          = (cfg.scan_ticks == '0) ? TICK_W'(1) : cfg.scan_ticks;
    t1             = tick_r + TICK_W'(1);

    case (q_item.op)
      OP_SYM: begin
        if (!rej_r) begin
          staged_nxt     = staged_push;
          staged_cnt_nxt = cnt_push;
          pend_nxt       = q_item.code;
        end
      end
      OP_POINT: begin
        if (!rej_r) begin
          staged_nxt     = staged_push;
          staged_cnt_nxt = cnt_push;
          pend_nxt       = CODE_NONE;
        end
      end
      OP_BAD: begin
        rej_out = 1'b1;
        if (!rej_r) begin
          rej_nxt = 1'b1;
          for (int i = 0; i < MAX_DIGITS; i++) staged_nxt[i] = '0;
          staged_cnt_nxt = '0;
          pend_nxt       = CODE_NONE;
        end
      end
      OP_END: begin
        if (!rej_r) begin
          shown_nxt     = staged_push;
          shown_cnt_nxt = cnt_push;
          si_mid        = '0;
          tick_nxt      = '0;
          on_nxt        = 1'b1;
        end
        for (int i = 0; i < MAX_DIGITS; i++) staged_nxt[i] = '0;
        staged_cnt_nxt = '0;
        pend_nxt       = CODE_NONE;
        rej_nxt        = 1'b0;
      end
      OP_TICK: begin
        if (on_r && n_cur > CW'(1)) begin
          if (t1 >= limit) begin
            tick_nxt = '0;
            si_mid   = (CW'(si0) + CW'(1) >= n_cur) ? '0 : si0 + SW'(1);
          end else begin
            tick_nxt = t1;
          end
        end
      end
      OP_OFF: on_nxt = 1'b0;
      default: ;
    endcase

    n_new    = (shown_cnt_nxt < d_eff) ? shown_cnt_nxt : d_eff;
    scan_nxt = (CW'(si_mid) >= n_new) ? '0 : si_mid;

    // line levels after this request
    cur_sym = shown_nxt[scan_nxt];
    for (int i = 0; i < MW; i++) mask[i] = (i < int'(d_eff));
    sel = MW'(1) << scan_nxt;
    lit = on_nxt && (n_new != '0);
    if (cfg.sign_positive) begin
      dig  = lit ? (mask & ~sel) : mask;
      segs = lit ? seg_pattern(cur_sym.code) : '0;
      pt   = lit & cur_sym.pt;
    end else begin
      dig  = lit ? sel : '0;
      segs = lit ? ~seg_pattern(cur_sym.code) : '1;
      pt   = ~(lit & cur_sym.pt);
    end
    out_data_nxt = {7'd0, rej_out, dig[DIG_LINES_W-1:0], pt, segs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= CODE_NONE;
      staged_cnt_r <= '0;
      shown_cnt_r  <= '0;
      rej_r        <= 1'b0;
      scan_r       <= '0;
      tick_r       <= '0;
      on_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        staged_r[i] <= '0;
        shown_r[i]  <= '0;
      end
    end else begin
      if (q_pop) begin
        pend_r       <= pend_nxt;
        staged_r     <= staged_nxt;
        staged_cnt_r <= staged_cnt_nxt;
        shown_r      <= shown_nxt;
        shown_cnt_r  <= shown_cnt_nxt;
        rej_r        <= rej_nxt;
        scan_r       <= scan_nxt;
        tick_r       <= tick_nxt;
        on_r         <= on_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// Seven-segment scan driver
// Parses display characters, commits strings and scans a multiplexed display.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per accepted beat. in_tuser is the kind (character,
//            end of string, tick, turn off), in_tdata the ASCII character.
//   out_*  : exactly one result per request, the line levels after it.
//   cfg_*  : register writes (digit count, polarity, scan ticks), taken on
//            any cycle with cfg_we high; write them only while idle.
// Timing:
//   An accepted request goes through the queue and the output register to
//   out_*. Sustained rate is one request per cycle while results are taken;
//   the back end updates all of its state in the cycle it pops a request.
// Reset:
//   rst_n low clears all control state and loads register defaults;
//   in_tready stays low until the first cycle after reset is released.
// Stall:
//   A held result keeps out_tdata stable; the two-entry queue takes up to
//   two more requests, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code[7:0]
  input  logic [sssd_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [sssd_pkg::KIND_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // segment_lines[6:0], point_line[7], digit_lines[15:8], string_rejected[16]
  output logic [sssd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [sssd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sssd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sssd_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_ready, q_pop, q_valid;
  item_t q_in_item, q_out_item;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digit_count   <= DIGIT_COUNT_RST;
      cfg_r.sign_positive <= 1'b1;
      cfg_r.scan_ticks    <= SCAN_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DIGIT_COUNT: cfg_r.digit_count   <= cfg_wdata[DCOUNT_W-1:0];
        REG_SIGN_POS:    cfg_r.sign_positive <= cfg_wdata[0];
        REG_SCAN_TICKS:  cfg_r.scan_ticks    <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: handshake and character classification.
  sssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  // Decoupling queue so a stalled result does not block the front at once.
  sssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .valid     (q_valid)
  );

  // Back: staging, display buffer, scan and output register.
  sssd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/sssd_checker.sv
// ----------------------------------------------------------------------------
// sssd_checker
// Port-level checks on the scan driver's request and result channels.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_assert.svh"

module sssd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sssd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // stalled result holds
  `SSSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a fresh result follows a taken request through the queue and output register
  `SSSD_ASSERT_IMP(a_rise_latency, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "result without request")

  // the queue only fills up behind a stalled result
  `SSSD_ASSERT_IMP(a_full_cause, clk, rst_n, !in_tready && $past(in_tready), $past(out_tvalid && !out_tready), "queue full without stall")

endmodule

bind seven_segment_scan_driver sssd_checker u_sssd_checker (.*);
